[hw/rtl/sms_pkg.sv]
`default_nettype none

package sms_pkg;

  // reset values of the configuration registers
  localparam logic [15:0] STEP_TIMEOUT_RST = 16'd2000;
  localparam logic [3:0]  RETRY_LIMIT_RST  = 4'd5;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIMEOUT = 1'b0,
    CFG_RETRY_LIMIT  = 1'b1
  } cfg_idx_t;

  // input action codes, also used as parked request codes
  localparam logic [2:0] ACT_POLL  = 3'd0;
  localparam logic [2:0] ACT_INIT  = 3'd1;
  localparam logic [2:0] ACT_OPEN  = 3'd2;
  localparam logic [2:0] ACT_CLOSE = 3'd3;
  localparam logic [2:0] ACT_FREE  = 3'd4;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // response kinds
  localparam logic [2:0] MSG_NONE   = 3'd0;
  localparam logic [2:0] MSG_INIT   = 3'd1;
  localparam logic [2:0] MSG_OPEN   = 3'd2;
  localparam logic [2:0] MSG_CLOSE  = 3'd3;
  localparam logic [2:0] MSG_FREE   = 3'd4;
  localparam logic [2:0] MSG_STATUS = 3'd5;

  localparam logic [1:0] AK_NONE    = 2'd0;
  localparam logic [1:0] AK_TIMEOUT = 2'd1;
  localparam logic [1:0] AK_HOME    = 2'd2;
  localparam logic [1:0] AK_FORCED  = 2'd3;

  localparam logic [1:0] MOT_NONE = 2'd0;
  localparam logic [1:0] MOT_FWD  = 2'd1;
  localparam logic [1:0] MOT_REV  = 2'd2;
  localparam logic [1:0] MOT_STOP = 2'd3;

  localparam logic [3:0] STEP_CODE_FQ = 4'd1;

endpackage

`default_nettype wire

[hw/rtl/shutter_motion_sequencer.sv]
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | action, run_direction, sensor and motor flags
// out_    | output    | out_valid / out_ready | response, alarm, motor, timer, step, error
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (step_timeout, retry_limit)
//
// one beat a cycle sustained while out_ is not stalled; an accepted beat passes through
// the input register and the result register around the step decision
// synchronous active-low reset returns to idle with no parked request and reloads
// the configuration defaults; out_ stalls back up through the input register to in_ready
// cfg_ready is always high
`default_nettype none

module shutter_motion_sequencer
  import sms_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_action,
  input  wire logic [1:0]           in_run_direction,
  input  wire logic                 in_sensor_open,
  input  wire logic                 in_motor_stopped,
  input  wire logic                 in_motor_start_ok,
  input  wire logic                 in_timeout_flag,
  input  wire logic [15:0]          in_position_sensors,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_msg_kind,
  output logic                      out_msg_alarm,
  output logic [1:0]                out_alarm_kind,
  output logic [3:0]                out_alarm_step,
  output logic [15:0]               out_alarm_sensors,
  output logic [1:0]                out_motor_cmd,
  output logic                      out_timer_load,
  output logic [15:0]               out_timer_value,
  output logic [3:0]                out_current_step,
  output logic                      out_sys_error,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  typedef enum logic [3:0] {
    IDLE     = 4'd0,
    FQ       = 4'd1,
    INIT_00  = 4'd2,
    INIT_04  = 4'd3,
    INIT_06  = 4'd4,
    INIT_08  = 4'd5,
    OPEN_00  = 4'd6,
    OPEN_04  = 4'd7,
    OPEN_06  = 4'd8,
    CLOSE_00 = 4'd9,
    CLOSE_04 = 4'd10,
    CLOSE_06 = 4'd11,
    FREE_00  = 4'd12,
    FREE_04  = 4'd13,
    FREE_06  = 4'd14
  } step_t;

  function automatic logic [2:0] group_of(input step_t s);
    logic [2:0] g;
    case (s)
      INIT_00, INIT_04, INIT_06, INIT_08: g = MSG_INIT;
      OPEN_00, OPEN_04, OPEN_06:          g = MSG_OPEN;
      CLOSE_00, CLOSE_04, CLOSE_06:       g = MSG_CLOSE;
      FREE_00, FREE_04, FREE_06:          g = MSG_FREE;
      default:                            g = MSG_STATUS;
    endcase
    return g;
  endfunction

  // configuration
  logic [15:0] step_timeout_r;
  logic [3:0]  retry_limit_r;

  // state
  step_t       step_r, step_nxt;
  logic [2:0]  parked_r, parked_nxt;
  logic [3:0]  retry_cnt_r, retry_cnt_nxt;
  logic [1:0]  dir_r, dir_nxt;

  // input register
  logic        s1_valid_r;
  logic [2:0]  s1_action_r;
  logic [1:0]  s1_dir_r;
  logic        s1_sens_r;
  logic        s1_stop_r;
  logic        s1_ok_r;
  logic        s1_to_r;
  logic [15:0] s1_pos_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  kind_r, kind_nxt;
  logic        alarm_r, alarm_nxt;
  logic [1:0]  akind_r, akind_nxt;
  logic [3:0]  astep_r, astep_nxt;
  logic [15:0] asens_r, asens_nxt;
  logic [1:0]  motor_r, motor_nxt;
  logic        tload_r, tload_nxt;
  logic [15:0] tval_r, tval_nxt;
  logic [3:0]  cur_step_r;
  logic        syserr_r, syserr_nxt;

  logic        s1_go;
  logic        in_acc;

  // decision helpers
  logic        do_alarm;
  logic [1:0]  alarm_sel;
  logic        do_retry;
  logic [1:0]  retry_sel;
  step_t       retry_to;
  logic [3:0]  retry_inc;
  logic        retry_hit;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign retry_inc = (retry_cnt_r == 4'hF) ? retry_cnt_r : retry_cnt_r + 4'd1;
  assign retry_hit = retry_inc >= retry_limit_r;

  always_comb begin
    step_nxt      = step_r;
    parked_nxt    = parked_r;
    retry_cnt_nxt = retry_cnt_r;
    dir_nxt       = dir_r;
    kind_nxt      = MSG_NONE;
    alarm_nxt     = 1'b0;
    akind_nxt     = AK_NONE;
    astep_nxt     = 4'd0;
    asens_nxt     = 16'd0;
    motor_nxt     = MOT_NONE;
    tload_nxt     = 1'b0;
    syserr_nxt    = 1'b0;
    do_alarm      = 1'b0;
    alarm_sel     = AK_NONE;
    do_retry      = 1'b0;
    retry_sel     = AK_TIMEOUT;
    retry_to      = step_r;

    if (step_r == IDLE) begin
      case (s1_action_r)
        ACT_POLL: begin
        end
        ACT_INIT: begin
          retry_cnt_nxt = 4'd0;
          step_nxt      = INIT_00;
          tload_nxt     = 1'b1;
          if (s1_ok_r) begin
            motor_nxt = MOT_FWD;
            step_nxt  = s1_sens_r ? INIT_04 : INIT_06;
          end
        end
        ACT_OPEN: begin
          retry_cnt_nxt = 4'd0;
          step_nxt      = OPEN_00;
          tload_nxt     = 1'b1;
          if (s1_sens_r) begin
            kind_nxt = MSG_OPEN;
            step_nxt = IDLE;
          end else if (s1_ok_r) begin
            motor_nxt = MOT_FWD;
            step_nxt  = OPEN_04;
          end
        end
        ACT_CLOSE: begin
          retry_cnt_nxt = 4'd0;
          step_nxt      = CLOSE_00;
          tload_nxt     = 1'b1;
          if (!s1_sens_r) begin
            kind_nxt = MSG_CLOSE;
            step_nxt = IDLE;
          end else if (s1_ok_r) begin
            motor_nxt = MOT_FWD;
            step_nxt  = CLOSE_04;
          end
        end
        ACT_FREE: begin
          dir_nxt   = s1_dir_r;
          step_nxt  = FREE_00;
          tload_nxt = 1'b1;
        end
        default: begin
          syserr_nxt = 1'b1;
        end
      endcase
    end else begin
      case (s1_action_r)
        ACT_POLL: begin
          case (step_r)
            FQ: begin
              if (s1_to_r) begin
                do_alarm  = 1'b1;
                alarm_sel = AK_TIMEOUT;
              end else if (s1_stop_r) begin
                tload_nxt  = 1'b1;
                parked_nxt = ACT_POLL;
                case (parked_r)
                  ACT_FREE: begin
                    kind_nxt = MSG_FREE;
                    step_nxt = IDLE;
                  end
                  ACT_INIT:  step_nxt = INIT_00;
                  ACT_OPEN:  step_nxt = OPEN_00;
                  ACT_CLOSE: step_nxt = CLOSE_00;
                  default:   step_nxt = IDLE;
                endcase
              end
            end
            INIT_00: begin
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = INIT_00;
              end else if (s1_ok_r) begin
                motor_nxt = MOT_FWD;
                step_nxt  = s1_sens_r ? INIT_04 : INIT_06;
                tload_nxt = 1'b1;
              end
            end
            INIT_04: begin
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = INIT_00;
              end else if (!s1_sens_r) begin
                step_nxt  = INIT_06;
                tload_nxt = 1'b1;
              end
            end
            INIT_06: begin
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = INIT_00;
              end else if (s1_sens_r) begin
                motor_nxt = MOT_STOP;
                step_nxt  = INIT_08;
                tload_nxt = 1'b1;
              end
            end
            INIT_08: begin
              retry_to = INIT_00;
              if (s1_to_r) begin
                do_retry = 1'b1;
              end else if (s1_stop_r) begin
                if (s1_sens_r) begin
                  kind_nxt  = MSG_INIT;
                  step_nxt  = IDLE;
                  tload_nxt = 1'b1;
                end else begin
                  do_retry  = 1'b1;
                  retry_sel = AK_HOME;
                end
              end
            end
            OPEN_00: begin
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = OPEN_00;
              end else if (s1_sens_r) begin
                kind_nxt  = MSG_OPEN;
                step_nxt  = IDLE;
                tload_nxt = 1'b1;
              end else if (s1_ok_r) begin
                motor_nxt = MOT_FWD;
                step_nxt  = OPEN_04;
                tload_nxt = 1'b1;
              end
            end
            OPEN_04: begin
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = OPEN_00;
              end else if (s1_sens_r) begin
                motor_nxt = MOT_STOP;
                step_nxt  = OPEN_06;
                tload_nxt = 1'b1;
              end
            end
            OPEN_06: begin
              retry_to = OPEN_00;
              if (s1_to_r) begin
                do_retry = 1'b1;
              end else if (s1_stop_r) begin
                if (s1_sens_r) begin
                  kind_nxt  = MSG_OPEN;
                  step_nxt  = IDLE;
                  tload_nxt = 1'b1;
                end else begin
                  do_retry  = 1'b1;
                  retry_sel = AK_HOME;
                end
              end
            end
            CLOSE_00: begin
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = CLOSE_00;
              end else if (!s1_sens_r) begin
                kind_nxt  = MSG_CLOSE;
                step_nxt  = IDLE;
                tload_nxt = 1'b1;
              end else if (s1_ok_r) begin
                motor_nxt = MOT_FWD;
                step_nxt  = CLOSE_04;
                tload_nxt = 1'b1;
              end
            end
            CLOSE_04: begin
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = CLOSE_00;
              end else if (!s1_sens_r) begin
                motor_nxt = MOT_STOP;
                step_nxt  = CLOSE_06;
                tload_nxt = 1'b1;
              end
            end
            CLOSE_06: begin
              retry_to = CLOSE_00;
              if (s1_to_r) begin
                do_retry = 1'b1;
              end else if (s1_stop_r) begin
                if (!s1_sens_r) begin
                  kind_nxt  = MSG_CLOSE;
                  step_nxt  = IDLE;
                  tload_nxt = 1'b1;
                end else begin
                  do_retry  = 1'b1;
                  retry_sel = AK_HOME;
                end
              end
            end
            FREE_00: begin
              if (dir_r == DIR_FWD || dir_r == DIR_REV) begin
                if (s1_ok_r) begin
                  motor_nxt = (dir_r == DIR_FWD) ? MOT_FWD : MOT_REV;
                  step_nxt  = FREE_06;
                  tload_nxt = 1'b1;
                end
              end else begin
                step_nxt   = IDLE;
                tload_nxt  = 1'b1;
                syserr_nxt = 1'b1;
              end
            end
            FREE_04, FREE_06: begin
              // free-run retry restarts at the close sequence
              if (s1_to_r) begin
                do_retry = 1'b1;
                retry_to = CLOSE_00;
              end else if (!s1_sens_r) begin
                motor_nxt = MOT_STOP;
                step_nxt  = FREE_06;
                tload_nxt = 1'b1;
              end
            end
            default: begin
              do_alarm   = 1'b1;
              alarm_sel  = AK_FORCED;
              syserr_nxt = 1'b1;
            end
          endcase
        end
        ACT_INIT, ACT_OPEN, ACT_CLOSE, ACT_FREE: begin
          // a free-run request while busy parks only as a stop request
          if (s1_action_r != ACT_FREE || s1_dir_r == DIR_STOP) begin
            if (s1_action_r != ACT_FREE) begin
              retry_cnt_nxt = 4'd0;
            end
            parked_nxt = s1_action_r;
            if (step_r != FQ) begin
              motor_nxt = MOT_STOP;
              step_nxt  = FQ;
              tload_nxt = 1'b1;
            end
          end
        end
        default: begin
          do_alarm   = 1'b1;
          alarm_sel  = AK_FORCED;
          syserr_nxt = 1'b1;
        end
      endcase
    end

    if (do_retry) begin
      retry_cnt_nxt = retry_inc;
      if (retry_hit) begin
        do_alarm  = 1'b1;
        alarm_sel = retry_sel;
      end else begin
        if (!s1_stop_r) begin
          motor_nxt = MOT_STOP;
        end
        step_nxt  = retry_to;
        tload_nxt = 1'b1;
      end
    end

    if (do_alarm) begin
      motor_nxt = MOT_STOP;
      kind_nxt  = group_of(step_r);
      alarm_nxt = 1'b1;
      akind_nxt = alarm_sel;
      astep_nxt = step_r;
      asens_nxt = s1_pos_r;
      step_nxt  = FQ;
      tload_nxt = 1'b1;
    end

    // every step change except the return to idle reloads the step timeout
    tval_nxt = (tload_nxt && step_nxt != IDLE) ? step_timeout_r : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_timeout_r <= STEP_TIMEOUT_RST;
      retry_limit_r  <= RETRY_LIMIT_RST;
      step_r         <= IDLE;
      parked_r       <= ACT_POLL;
      retry_cnt_r    <= 4'd0;
      dir_r          <= DIR_STOP;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STEP_TIMEOUT: step_timeout_r <= cfg_data;
          CFG_RETRY_LIMIT:  retry_limit_r  <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        step_r      <= step_nxt;
        parked_r    <= parked_nxt;
        retry_cnt_r <= retry_cnt_nxt;
        dir_r       <= dir_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // payload, no reset
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_dir_r    <= in_run_direction;
      s1_sens_r   <= in_sensor_open;
      s1_stop_r   <= in_motor_stopped;
      s1_ok_r     <= in_motor_start_ok;
      s1_to_r     <= in_timeout_flag;
      s1_pos_r    <= in_position_sensors;
    end
    if (s1_go) begin
      kind_r     <= kind_nxt;
      alarm_r    <= alarm_nxt;
      akind_r    <= akind_nxt;
      astep_r    <= astep_nxt;
      asens_r    <= asens_nxt;
      motor_r    <= motor_nxt;
      tload_r    <= tload_nxt;
      tval_r     <= tval_nxt;
      cur_step_r <= step_nxt;
      syserr_r   <= syserr_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_msg_kind      = kind_r;
  assign out_msg_alarm     = alarm_r;
  assign out_alarm_kind    = akind_r;
  assign out_alarm_step    = astep_r;
  assign out_alarm_sensors = asens_r;
  assign out_motor_cmd     = motor_r;
  assign out_timer_load    = tload_r;
  assign out_timer_value   = tval_r;
  assign out_current_step  = cur_step_r;
  assign out_sys_error     = syserr_r;

endmodule

`default_nettype wire

[hw/rtl/sms_checker.sv]
`default_nettype none

module sms_checker
  import sms_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           out_msg_kind,
  input wire logic                 out_msg_alarm,
  input wire logic [1:0]           out_alarm_kind,
  input wire logic [3:0]           out_alarm_step,
  input wire logic [15:0]          out_alarm_sensors,
  input wire logic [1:0]           out_motor_cmd,
  input wire logic                 out_timer_load,
  input wire logic [15:0]          out_timer_value,
  input wire logic [3:0]           out_current_step
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_step)
      && $stable(out_msg_kind) && $stable(out_motor_cmd) && $stable(out_timer_value))
    else $error("result beat changed while stalled");

  // no reload value without a timer load
  a_tval_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_timer_load |-> out_timer_value == 16'd0)
    else $error("timer value without timer load");

  // an alarm stops the motor and enters force quit with a fresh timer
  a_alarm_fq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_alarm |-> out_motor_cmd == MOT_STOP
      && out_current_step == STEP_CODE_FQ && out_timer_load)
    else $error("alarm without stop and force quit");

  // alarm details only come with an alarm response
  a_alarm_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_msg_alarm |-> out_alarm_kind == AK_NONE
      && out_alarm_step == 4'd0 && out_alarm_sensors == 16'd0)
    else $error("alarm fields set without alarm");

endmodule

bind shutter_motion_sequencer sms_checker u_sms_checker (.*);

`default_nettype wire

[dv/tb_shutter_motion_sequencer.sv]
`timescale 1ns / 100ps

module tb_shutter_motion_sequencer;
  import sms_pkg::*;

  // step encoding of the sequencer
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FQ       = STEP_CODE_FQ;
  localparam logic [3:0] S_INIT_00  = 4'd2;
  localparam logic [3:0] S_INIT_04  = 4'd3;
  localparam logic [3:0] S_INIT_06  = 4'd4;
  localparam logic [3:0] S_INIT_08  = 4'd5;
  localparam logic [3:0] S_OPEN_00  = 4'd6;
  localparam logic [3:0] S_OPEN_04  = 4'd7;
  localparam logic [3:0] S_OPEN_06  = 4'd8;
  localparam logic [3:0] S_CLOSE_00 = 4'd9;
  localparam logic [3:0] S_CLOSE_04 = 4'd10;
  localparam logic [3:0] S_CLOSE_06 = 4'd11;
  localparam logic [3:0] S_FREE_00  = 4'd12;
  localparam logic [3:0] S_FREE_04  = 4'd13;
  localparam logic [3:0] S_FREE_06  = 4'd14;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  run_direction;
    logic        sensor_open;
    logic        motor_stopped;
    logic        motor_start_ok;
    logic        timeout_flag;
    logic [15:0] position_sensors;
  } shutter_item_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic        msg_alarm;
    logic [1:0]  alarm_kind;
    logic [3:0]  alarm_step;
    logic [15:0] alarm_sensors;
    logic [1:0]  motor_cmd;
    logic        timer_load;
    logic [15:0] timer_value;
    logic [3:0]  current_step;
    logic        sys_error;
  } shutter_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_action = '0;
  logic [1:0]           in_run_direction = '0;
  logic                 in_sensor_open = 1'b0;
  logic                 in_motor_stopped = 1'b0;
  logic                 in_motor_start_ok = 1'b0;
  logic                 in_timeout_flag = 1'b0;
  logic [15:0]          in_position_sensors = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_msg_kind;
  logic                 out_msg_alarm;
  logic [1:0]           out_alarm_kind;
  logic [3:0]           out_alarm_step;
  logic [15:0]          out_alarm_sensors;
  logic [1:0]           out_motor_cmd;
  logic                 out_timer_load;
  logic [15:0]          out_timer_value;
  logic [3:0]           out_current_step;
  logic                 out_sys_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STEP_TIMEOUT;
  logic [15:0]          cfg_data = '0;

  shutter_motion_sequencer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_run_direction    (in_run_direction),
    .in_sensor_open      (in_sensor_open),
    .in_motor_stopped    (in_motor_stopped),
    .in_motor_start_ok   (in_motor_start_ok),
    .in_timeout_flag     (in_timeout_flag),
    .in_position_sensors (in_position_sensors),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_msg_kind        (out_msg_kind),
    .out_msg_alarm       (out_msg_alarm),
    .out_alarm_kind      (out_alarm_kind),
    .out_alarm_step      (out_alarm_step),
    .out_alarm_sensors   (out_alarm_sensors),
    .out_motor_cmd       (out_motor_cmd),
    .out_timer_load      (out_timer_load),
    .out_timer_value     (out_timer_value),
    .out_current_step    (out_current_step),
    .out_sys_error       (out_sys_error),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // sequencer state as the testbench sees it
  logic [3:0]   sq_step = S_IDLE;
  logic [2:0]   sq_parked = ACT_POLL;
  logic [3:0]   sq_retries = '0;
  logic [1:0]   sq_dir = DIR_STOP;
  logic [15:0]  reg_timeout = STEP_TIMEOUT_RST;
  logic [3:0]   reg_limit = RETRY_LIMIT_RST;
  shutter_item_t cur;
  shutter_res_t  nx;

  shutter_res_t pending_responses[$];
  int n_errors = 0;
  int in_gap_pct = 21;
  int out_stall_pct = 84;
  int quiet_cycles = 0;

  function automatic void goto_step(input logic [3:0] s, input logic [15:0] tv);
    sq_step = s;
    nx.timer_load = 1'b1;
    nx.timer_value = tv;
  endfunction

  function automatic void finish_ok(input logic [2:0] kind);
    nx.msg_kind = kind;
    nx.msg_alarm = 1'b0;
    goto_step(S_IDLE, 16'd0);
  endfunction

  function automatic void raise_alarm(input logic [1:0] kind);
    nx.motor_cmd = MOT_STOP;
    if (sq_step >= S_INIT_00 && sq_step <= S_INIT_08) nx.msg_kind = MSG_INIT;
    else if (sq_step >= S_OPEN_00 && sq_step <= S_OPEN_06) nx.msg_kind = MSG_OPEN;
    else if (sq_step >= S_CLOSE_00 && sq_step <= S_CLOSE_06) nx.msg_kind = MSG_CLOSE;
    else if (sq_step >= S_FREE_00 && sq_step <= S_FREE_06) nx.msg_kind = MSG_FREE;
    else nx.msg_kind = MSG_STATUS;
    nx.msg_alarm = 1'b1;
    nx.alarm_kind = kind;
    nx.alarm_step = sq_step;
    nx.alarm_sensors = cur.position_sensors;
    goto_step(S_FQ, reg_timeout);
  endfunction

  function automatic void retry_or_alarm(input logic [1:0] kind, input logic [3:0] restart);
    if (sq_retries != 4'd15) sq_retries++;
    if (sq_retries >= reg_limit) begin
      raise_alarm(kind);
    end else begin
      if (!cur.motor_stopped) nx.motor_cmd = MOT_STOP;
      goto_step(restart, reg_timeout);
    end
  endfunction

  function automatic void start_forward(input logic [3:0] next);
    if (cur.motor_start_ok) begin
      nx.motor_cmd = MOT_FWD;
      goto_step(next, reg_timeout);
    end
  endfunction

  function automatic void begin_init();
    if (cur.sensor_open) start_forward(S_INIT_04);
    else start_forward(S_INIT_06);
  endfunction

  function automatic void begin_open();
    if (cur.sensor_open) finish_ok(MSG_OPEN);
    else start_forward(S_OPEN_04);
  endfunction

  function automatic void begin_close();
    if (!cur.sensor_open) finish_ok(MSG_CLOSE);
    else start_forward(S_CLOSE_04);
  endfunction

  function automatic void park_request(input logic [2:0] req);
    sq_parked = req;
    if (sq_step != S_FQ) begin
      nx.motor_cmd = MOT_STOP;
      goto_step(S_FQ, reg_timeout);
    end
  endfunction

  function automatic shutter_res_t predict_response(input shutter_item_t it);
    cur = it;
    nx = '0;
    if (sq_step == S_IDLE) begin
      case (it.action)
        ACT_POLL: ;
        ACT_INIT: begin
          sq_retries = '0;
          goto_step(S_INIT_00, reg_timeout);
          begin_init();
        end
        ACT_OPEN: begin
          sq_retries = '0;
          goto_step(S_OPEN_00, reg_timeout);
          begin_open();
        end
        ACT_CLOSE: begin
          sq_retries = '0;
          goto_step(S_CLOSE_00, reg_timeout);
          begin_close();
        end
        ACT_FREE: begin
          sq_dir = it.run_direction;
          goto_step(S_FREE_00, reg_timeout);
        end
        default: nx.sys_error = 1'b1;
      endcase
    end else begin
      case (it.action)
        ACT_POLL: begin
          case (sq_step)
            S_FQ: begin
              if (it.timeout_flag) begin
                raise_alarm(AK_TIMEOUT);
              end else if (it.motor_stopped) begin
                case (sq_parked)
                  ACT_FREE:  finish_ok(MSG_FREE);
                  ACT_INIT:  goto_step(S_INIT_00, reg_timeout);
                  ACT_OPEN:  goto_step(S_OPEN_00, reg_timeout);
                  ACT_CLOSE: goto_step(S_CLOSE_00, reg_timeout);
                  default:   goto_step(S_IDLE, 16'd0);
                endcase
                sq_parked = ACT_POLL;
              end
            end
            S_INIT_00: begin
              if (it.timeout_flag) retry_or_alarm(AK_TIMEOUT, S_INIT_00);
              else begin_init();
            end
            S_INIT_04: begin
              if (it.timeout_flag) retry_or_alarm(AK_TIMEOUT, S_INIT_00);
              else if (!it.sensor_open) goto_step(S_INIT_06, reg_timeout);
            end
            S_INIT_06: begin
              if (it.timeout_flag) begin
                retry_or_alarm(AK_TIMEOUT, S_INIT_00);
              end else if (it.sensor_open) begin
                nx.motor_cmd = MOT_STOP;
                goto_step(S_INIT_08, reg_timeout);
              end
            end
            S_INIT_08: begin
              if (it.timeout_flag) begin
                retry_or_alarm(AK_TIMEOUT, S_INIT_00);
              end else if (it.motor_stopped) begin
                if (it.sensor_open) finish_ok(MSG_INIT);
                else retry_or_alarm(AK_HOME, S_INIT_00);
              end
            end
            S_OPEN_00: begin
              if (it.timeout_flag) retry_or_alarm(AK_TIMEOUT, S_OPEN_00);
              else begin_open();
            end
            S_OPEN_04: begin
              if (it.timeout_flag) begin
                retry_or_alarm(AK_TIMEOUT, S_OPEN_00);
              end else if (it.sensor_open) begin
                nx.motor_cmd = MOT_STOP;
                goto_step(S_OPEN_06, reg_timeout);
              end
            end
            S_OPEN_06: begin
              if (it.timeout_flag) begin
                retry_or_alarm(AK_TIMEOUT, S_OPEN_00);
              end else if (it.motor_stopped) begin
                if (it.sensor_open) finish_ok(MSG_OPEN);
                else retry_or_alarm(AK_HOME, S_OPEN_00);
              end
            end
            S_CLOSE_00: begin
              if (it.timeout_flag) retry_or_alarm(AK_TIMEOUT, S_CLOSE_00);
              else begin_close();
            end
            S_CLOSE_04: begin
              if (it.timeout_flag) begin
                retry_or_alarm(AK_TIMEOUT, S_CLOSE_00);
              end else if (!it.sensor_open) begin
                nx.motor_cmd = MOT_STOP;
                goto_step(S_CLOSE_06, reg_timeout);
              end
            end
            S_CLOSE_06: begin
              if (it.timeout_flag) begin
                retry_or_alarm(AK_TIMEOUT, S_CLOSE_00);
              end else if (it.motor_stopped) begin
                if (!it.sensor_open) finish_ok(MSG_CLOSE);
                else retry_or_alarm(AK_HOME, S_CLOSE_00);
              end
            end
            S_FREE_00: begin
              if (sq_dir == DIR_FWD || sq_dir == DIR_REV) begin
                if (it.motor_start_ok) begin
                  nx.motor_cmd = (sq_dir == DIR_FWD) ? MOT_FWD : MOT_REV;
                  goto_step(S_FREE_06, reg_timeout);
                end
              end else begin
                goto_step(S_IDLE, 16'd0);
                nx.sys_error = 1'b1;
              end
            end
            S_FREE_04, S_FREE_06: begin
              // free-run retry falls into the close procedure
              if (it.timeout_flag) begin
                retry_or_alarm(AK_TIMEOUT, S_CLOSE_00);
              end else if (!it.sensor_open) begin
                nx.motor_cmd = MOT_STOP;
                goto_step(S_FREE_06, reg_timeout);
              end
            end
            default: begin
              raise_alarm(AK_FORCED);
              nx.sys_error = 1'b1;
            end
          endcase
        end
        ACT_INIT, ACT_OPEN, ACT_CLOSE: begin
          sq_retries = '0;
          park_request(it.action);
        end
        ACT_FREE: begin
          if (it.run_direction == DIR_STOP) park_request(ACT_FREE);
        end
        default: begin
          raise_alarm(AK_FORCED);
          nx.sys_error = 1'b1;
        end
      endcase
    end
    nx.current_step = sq_step;
    return nx;
  endfunction

  function automatic shutter_item_t beat_of(input logic [2:0] action, input logic [1:0] dir,
                                            input logic sens, input logic stopped,
                                            input logic start_ok, input logic tmo,
                                            input logic [15:0] pos);
    shutter_item_t it;
    it.action = action;
    it.run_direction = dir;
    it.sensor_open = sens;
    it.motor_stopped = stopped;
    it.motor_start_ok = start_ok;
    it.timeout_flag = tmo;
    it.position_sensors = pos;
    return it;
  endfunction

  // mostly well-formed traffic for the current step, with some noise
  function automatic shutter_item_t rand_item();
    shutter_item_t it;
    logic [31:0] raw;
    int roll;
    raw = $urandom;
    it = raw[$bits(shutter_item_t)-1:0];
    roll = $urandom_range(99);
    if (sq_step == S_IDLE) begin
      if (roll < 10) it.action = ACT_POLL;
      else if (roll < 16) it.action = 3'($urandom_range(7, 5));
      else it.action = 3'($urandom_range(ACT_FREE, ACT_INIT));
      if (it.action == ACT_FREE && $urandom_range(3) != 0)
        it.run_direction = 2'($urandom_range(DIR_REV, DIR_FWD));
    end else begin
      if (roll < 88) it.action = ACT_POLL;
      else if (roll < 97) it.action = 3'($urandom_range(ACT_FREE, ACT_INIT));
      else it.action = 3'($urandom_range(7, 5));
      it.timeout_flag = ($urandom_range(99) < 8);
      it.motor_start_ok = ($urandom_range(3) != 0);
    end
    return it;
  endfunction

  task automatic send_beat(input shutter_item_t it);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_valid            <= 1'b1;
    in_action           <= it.action;
    in_run_direction    <= it.run_direction;
    in_sensor_open      <= it.sensor_open;
    in_motor_stopped    <= it.motor_stopped;
    in_motor_start_ok   <= it.motor_start_ok;
    in_timeout_flag     <= it.timeout_flag;
    in_position_sensors <= it.position_sensors;
    do @(posedge clk); while (!in_ready);
    pending_responses.push_back(predict_response(it));
  endtask

  task automatic wait_all_responses();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_STEP_TIMEOUT) reg_timeout = value;
    else reg_limit = value[3:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] tmo, input logic [3:0] lim);
    logic [15:0] lim_word;
    wait_all_responses();
    // upper bits of the limit word are don't-care, keep them noisy
    lim_word = 16'($urandom);
    lim_word[3:0] = lim;
    write_reg(CFG_STEP_TIMEOUT, tmo);
    write_reg(CFG_RETRY_LIMIT, lim_word);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : rx_check
    shutter_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $error("response beat with nothing pending, step %0d", out_current_step);
        n_errors++;
      end else begin
        want = pending_responses.pop_front();
        check_field("msg_kind", 16'(want.msg_kind), 16'(out_msg_kind));
        check_field("msg_alarm", 16'(want.msg_alarm), 16'(out_msg_alarm));
        check_field("alarm_kind", 16'(want.alarm_kind), 16'(out_alarm_kind));
        check_field("alarm_step", 16'(want.alarm_step), 16'(out_alarm_step));
        check_field("alarm_sensors", want.alarm_sensors, out_alarm_sensors);
        check_field("motor_cmd", 16'(want.motor_cmd), 16'(out_motor_cmd));
        check_field("timer_load", 16'(want.timer_load), 16'(out_timer_load));
        check_field("timer_value", want.timer_value, out_timer_value);
        check_field("current_step", 16'(want.current_step), 16'(out_current_step));
        check_field("sys_error", 16'(want.sys_error), 16'(out_sys_error));
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_shutter_motion_sequencer: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_idle_requests();
    send_beat(beat_of(ACT_POLL, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    send_beat(beat_of(3'd7, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    // close with the shutter already shut, open with it already open
    send_beat(beat_of(ACT_CLOSE, DIR_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_OPEN, DIR_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000));
    // bad free-run direction drops back to idle on the next poll
    send_beat(beat_of(ACT_FREE, 2'd3, 1'b0, 1'b0, 1'b1, 1'b0, 16'h5A5A));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b0, 1'b1, 1'b0, 16'hA5A5));
    send_beat(beat_of(ACT_INIT, DIR_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 16'h00FF));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b1, 1'b0, 1'b1, 1'b0, 16'hFF00));
  endtask

  task automatic test_busy_preemption();
    send_beat(beat_of(3'd5, DIR_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_CLOSE, DIR_STOP, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000));
    // nonzero direction while busy is dropped, zero direction parks
    send_beat(beat_of(ACT_FREE, DIR_REV, 1'b1, 1'b1, 1'b1, 1'b1, 16'h1234));
    send_beat(beat_of(ACT_FREE, DIR_STOP, 1'b1, 1'b0, 1'b1, 1'b0, 16'h4321));
    // request during force-quit replaces the parked one
    send_beat(beat_of(ACT_OPEN, DIR_STOP, 1'b0, 1'b1, 1'b1, 1'b1, 16'h8001));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b1, 1'b0, 1'b1, 16'hA204));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000));
  endtask

  task automatic test_retry_alarm();
    // zero limit alarms on the first timeout, zero timer value
    set_config(16'd0, 4'd0);
    send_beat(beat_of(ACT_OPEN, DIR_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b0, 1'b0, 1'b1, 16'hC3C3));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000));
    // free-run keeps the retry count, its retry lands in close
    set_config(16'hFFFF, 4'd3);
    send_beat(beat_of(ACT_FREE, DIR_FWD, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0000));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b1, 1'b1, 1'b0, 1'b0, 16'hBEEF));
    send_beat(beat_of(ACT_POLL, DIR_STOP, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000));
  endtask

  task automatic test_random_traffic();
    logic [15:0] tmo;
    logic [3:0] lim;
    int chunk;
    for (chunk = 0; chunk < 12; chunk++) begin
      case (chunk / 4)
        0: begin
          in_gap_pct = 21;
          out_stall_pct = 84;
        end
        1: begin
          in_gap_pct = 84;
          out_stall_pct = 21;
        end
        default: begin
          in_gap_pct = 0;
          out_stall_pct = 0;
        end
      endcase
      case (chunk % 4)
        0: tmo = 16'hFFFF;
        1: tmo = 16'd1;
        2: tmo = 16'($urandom);
        default: tmo = 16'd0;
      endcase
      case ((chunk + chunk / 4) % 4)
        0: lim = 4'd15;
        1: lim = 4'd1;
        2: lim = 4'($urandom_range(6, 2));
        default: lim = 4'd0;
      endcase
      set_config(tmo, lim);
      repeat (104) send_beat(rand_item());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_requests();
    test_busy_preemption();
    test_retry_alarm();
    test_random_traffic();
    wait_all_responses();
    repeat (4) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_shutter_motion_sequencer: done, clean");
    end else begin
      $display("tb_shutter_motion_sequencer: done, errors");
    end
    $finish;
  end

endmodule
